>>> rtl/core/assert_macros.svh
// Assertion macros shared by the scaler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define BIS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("Scaler assertion failed.");

// Consequent checked in the cycle after the antecedent.
`define BIS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("Scaler assertion failed.");

`endif

>>> rtl/core/bis_pkg.sv
// Types, constants and the pixel blend function of the image scaler.
`default_nettype none

package bis_pkg;

	// Field widths.
	localparam int COL_W  = 12;
	localparam int PIX_W  = 32;
	localparam int SZ_W   = 13;
	localparam int STEP_W = 25;
	localparam int PROD_W = 38;
	localparam int POS_W  = 40;
	localparam int BASE_W = 24;
	localparam int CFG_IW = 3;
	localparam int CFG_DW = 12;

	// Register indexes of the configuration port.
	localparam logic [CFG_IW-1:0] CFG_SRC_WIDTH  = 3'd0;
	localparam logic [CFG_IW-1:0] CFG_SRC_HEIGHT = 3'd1;
	localparam logic [CFG_IW-1:0] CFG_DST_WIDTH  = 3'd2;
	localparam logic [CFG_IW-1:0] CFG_DST_HEIGHT = 3'd3;
	localparam logic [CFG_IW-1:0] CFG_OFFSET_X   = 3'd4;
	localparam logic [CFG_IW-1:0] CFG_OFFSET_Y   = 3'd5;
	localparam logic [CFG_IW-1:0] CFG_FILTER     = 3'd6;

	// Operation codes and filter modes.
	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;
	localparam logic MODE_BILINEAR = 1'b1;

	// Lane masks and fixed-point constants.
	localparam logic [31:0] RB_MASK    = 32'h00FF00FF;
	localparam logic [31:0] AG_MASK    = 32'hFF00FF00;
	localparam logic [31:0] ALPHA_MASK = 32'hFF000000;
	localparam logic [POS_W-1:0] HALF_BIAS = 40'd32768;
	localparam logic [POS_W-1:0] ONE_BIAS  = 40'd65536;
	localparam logic [8:0] WEIGHT_ONE = 9'd256;

	// Blends two ARGB pixels with an 8-bit weight in two 16-bit lane pairs.
	function automatic logic [31:0] blend(input logic [31:0] a, input logic [31:0] b,
		input logic [7:0] t);
		logic [31:0] it;
		logic [31:0] tw;
		logic [31:0] rb;
		logic [31:0] ag;
		it = 32'(WEIGHT_ONE - {1'b0, t});
		tw = 32'(t);
		rb = ((((a & RB_MASK) * it) + ((b & RB_MASK) * tw)) >> 8) & RB_MASK;
		ag = ((((a >> 8) & RB_MASK) * it) + (((b >> 8) & RB_MASK) * tw)) & AG_MASK;
		return rb | ag;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/bis_if.sv
// Handshake channel interfaces of the image scaler.
`default_nettype none

interface bis_in_if;
	import bis_pkg::*;
	logic             valid;
	logic             ready;
	logic             operation;
	logic [COL_W-1:0] col;
	logic [COL_W-1:0] row;
	logic [PIX_W-1:0] pixel;
	modport source (output valid, operation, col, row, pixel, input ready);
	modport sink (input valid, operation, col, row, pixel, output ready);
endinterface

interface bis_out_if;
	import bis_pkg::*;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] out_pixel;
	modport source (output valid, out_pixel, input ready);
	modport sink (input valid, out_pixel, output ready);
endinterface

interface bis_cfg_if;
	import bis_pkg::*;
	logic              valid;
	logic              ready;
	logic [CFG_IW-1:0] index;
	logic [CFG_DW-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/bilinear_image_scaler.sv
// Top level of the image scaler: frame store, step divider and sample pipeline.
//
//   Channel  Direction  Carries
//   cfg      in         register index and write data
//   item     in         operation, col, row, pixel
//   result   out        out_pixel
//
// One request is taken per cycle unless a result is held or the divider is busy.
// A write to a size register starts a one-bit-per-cycle step divider that keeps
// item.ready low while it runs. The frame store holds no reset and is not cleared.
// All stages advance together; a held result stalls the pipeline but the input is
// still taken in the cycle in which the waiting result is taken.
`default_nettype none

module bilinear_image_scaler #(
	parameter int MAX_SRC_WIDTH  = 256,
	parameter int MAX_SRC_HEIGHT = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	bis_cfg_if.sink   cfg,
	bis_in_if.sink    item,
	bis_out_if.source result
);
	import bis_pkg::*;
	`include "assert_macros.svh"

	localparam int XW = (MAX_SRC_WIDTH > 1) ? $clog2(MAX_SRC_WIDTH) : 1;
	localparam int YW = (MAX_SRC_HEIGHT > 1) ? $clog2(MAX_SRC_HEIGHT) : 1;
	localparam int HALF_W = (MAX_SRC_WIDTH + 1) / 2;
	localparam int HALF_H = (MAX_SRC_HEIGHT + 1) / 2;
	localparam int BANK_DEPTH = HALF_W * HALF_H;
	localparam int BAW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

	// Configuration registers.
	logic [8:0]        src_width_q, src_height_q;
	logic [COL_W-1:0]  dst_width_q, dst_height_q, offset_x_q, offset_y_q;
	logic              filter_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= 9'd256;
			src_height_q <= 9'd256;
			dst_width_q  <= 12'd256;
			dst_height_q <= 12'd256;
			offset_x_q   <= '0;
			offset_y_q   <= '0;
			filter_q     <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_SRC_WIDTH:  src_width_q  <= cfg.data[8:0];
				CFG_SRC_HEIGHT: src_height_q <= cfg.data[8:0];
				CFG_DST_WIDTH:  dst_width_q  <= cfg.data;
				CFG_DST_HEIGHT: dst_height_q <= cfg.data;
				CFG_OFFSET_X:   offset_x_q   <= cfg.data;
				CFG_OFFSET_Y:   offset_y_q   <= cfg.data;
				CFG_FILTER:     filter_q     <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// Effective source size, clamped to the store, and the largest indexes.
	logic [SZ_W-1:0] sw, sh, max_x, max_y;
	logic            copy_mode, bilinear;

	always_comb begin
		if (src_width_q == 9'd0) sw = SZ_W'(1);
		else if (SZ_W'(src_width_q) > SZ_W'(MAX_SRC_WIDTH)) sw = SZ_W'(MAX_SRC_WIDTH);
		else sw = SZ_W'(src_width_q);
		if (src_height_q == 9'd0) sh = SZ_W'(1);
		else if (SZ_W'(src_height_q) > SZ_W'(MAX_SRC_HEIGHT)) sh = SZ_W'(MAX_SRC_HEIGHT);
		else sh = SZ_W'(src_height_q);
		max_x = sw - SZ_W'(1);
		max_y = sh - SZ_W'(1);
		copy_mode = ({1'b0, dst_width_q} == sw) && ({1'b0, dst_height_q} == sh);
		bilinear = (filter_q == MODE_BILINEAR) && !copy_mode;
	end

	// Restoring divider for the 9.16 steps; the shift register ends as the quotient.
	logic              busy_q, div_init_q;
	logic [4:0]        cnt_q;
	logic [STEP_W-1:0] step_x_q, step_y_q;
	logic [COL_W-1:0]  rem_x_q, rem_y_q;
	logic [COL_W:0]    trial_x, trial_y;
	logic              ge_x, ge_y, size_write;

	assign size_write = cfg.valid && (cfg.index == CFG_SRC_WIDTH ||
		cfg.index == CFG_SRC_HEIGHT || cfg.index == CFG_DST_WIDTH ||
		cfg.index == CFG_DST_HEIGHT);
	assign trial_x = {rem_x_q, step_x_q[STEP_W-1]};
	assign trial_y = {rem_y_q, step_y_q[STEP_W-1]};
	assign ge_x = trial_x >= {1'b0, dst_width_q};
	assign ge_y = trial_y >= {1'b0, dst_height_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			div_init_q <= 1'b0;
			cnt_q      <= '0;
			step_x_q   <= STEP_W'(32'h10000);
			step_y_q   <= STEP_W'(32'h10000);
			rem_x_q    <= '0;
			rem_y_q    <= '0;
		end else if (size_write) begin
			busy_q     <= 1'b1;
			div_init_q <= 1'b1;
		end else if (div_init_q) begin
			div_init_q <= 1'b0;
			cnt_q      <= 5'(STEP_W);
			step_x_q   <= STEP_W'({sw, 16'h0000});
			step_y_q   <= STEP_W'({sh, 16'h0000});
			rem_x_q    <= '0;
			rem_y_q    <= '0;
		end else if (busy_q) begin
			cnt_q    <= cnt_q - 5'd1;
			step_x_q <= {step_x_q[STEP_W-2:0], ge_x};
			step_y_q <= {step_y_q[STEP_W-2:0], ge_y};
			rem_x_q  <= ge_x ? COL_W'(trial_x - {1'b0, dst_width_q}) : trial_x[COL_W-1:0];
			rem_y_q  <= ge_y ? COL_W'(trial_y - {1'b0, dst_height_q}) : trial_y[COL_W-1:0];
			if (cnt_q == 5'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Global advance: every stage moves unless a result is held at the output.
	logic out_valid_q;
	logic en, acc;

	assign en = !out_valid_q || result.ready;
	assign item.ready = en && !busy_q && !div_init_q;
	assign acc = item.valid && item.ready;

	// Stage 1: destination coordinates, visibility and load range.
	logic [SZ_W-1:0] dx, dy;
	logic            keep;
	logic [XW-1:0]   cx_in;
	logic [YW-1:0]   cy_in;

	always_comb begin
		dx = {1'b0, offset_x_q} + {1'b0, item.col};
		dy = {1'b0, offset_y_q} + {1'b0, item.row};
		if (item.operation == OP_SAMPLE) begin
			keep  = (dx < {1'b0, dst_width_q}) && (dy < {1'b0, dst_height_q});
			cx_in = dx[XW-1:0];
			cy_in = dy[YW-1:0];
		end else begin
			keep  = ({1'b0, item.col} < SZ_W'(MAX_SRC_WIDTH)) &&
				({1'b0, item.row} < SZ_W'(MAX_SRC_HEIGHT));
			cx_in = item.col[XW-1:0];
			cy_in = item.row[YW-1:0];
		end
	end

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic op_s1, op_s2, op_s3, op_s4, op_s5;
	logic [PIX_W-1:0] pixel_s1, pixel_s2, pixel_s3, pixel_s4, pixel_s5;
	logic [SZ_W-1:0]  kx_s1, ky_s1;
	logic [XW-1:0]    cx_s1, cx_s2, cx_s3;
	logic [YW-1:0]    cy_s1, cy_s2, cy_s3;
	logic [PROD_W-1:0] prod_x_s2, prod_y_s2;
	logic [POS_W-1:0]  pos_x_s3, pos_y_s3;
	logic [XW-1:0]    x0_s4, x1_s4;
	logic [YW-1:0]    y0_s4, y1_s4;
	logic [7:0]       tx_s4, ty_s4, tx_s5, ty_s5, tx_s6, ty_s6, tx_s7;
	logic             alpha_s4, alpha_s5, alpha_s6, alpha_s7;
	logic [BAW-1:0]   addr_s5 [4];
	logic [1:0]       wbank_s5;
	logic             x0p_s5, x1p_s5, y0p_s5, y1p_s5;
	logic             x0p_s6, x1p_s6, y0p_s6, y1p_s6;
	logic [31:0]      rd_s6 [4];
	logic [31:0]      left_s7, right_s7;
	logic [31:0]      out_pixel_q;

	// Valid bits: loads stop after the store, samples go on to the output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1 <= acc && keep;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5 && (op_s5 == OP_SAMPLE);
			v_s7 <= v_s6;
			out_valid_q <= v_s7;
		end
	end

	// Stage 4 index arithmetic: floor or rounded index, clamped to the source.
	logic [BASE_W-1:0] bx, by, bxm1, bym1, mx, my, x0c, x1c, y0c, y1c;

	always_comb begin
		bx = pos_x_s3[POS_W-1:16];
		by = pos_y_s3[POS_W-1:16];
		bxm1 = bx - BASE_W'(1);
		bym1 = by - BASE_W'(1);
		mx = BASE_W'(max_x);
		my = BASE_W'(max_y);
		if (bx == '0) x0c = '0;
		else x0c = (bxm1 > mx) ? mx : bxm1;
		if (by == '0) y0c = '0;
		else y0c = (bym1 > my) ? my : bym1;
		x1c = bilinear ? ((bx > mx) ? mx : bx) : x0c;
		y1c = bilinear ? ((by > my) ? my : by) : y0c;
	end

	// Payload registers of all stages.
	always_ff @(posedge clk) begin
		if (en) begin
			// Stage 1.
			op_s1    <= item.operation;
			pixel_s1 <= item.pixel;
			kx_s1    <= dx;
			ky_s1    <= dy;
			cx_s1    <= cx_in;
			cy_s1    <= cy_in;
			// Stage 2: sample index times step.
			op_s2     <= op_s1;
			pixel_s2  <= pixel_s1;
			cx_s2     <= cx_s1;
			cy_s2     <= cy_s1;
			prod_x_s2 <= PROD_W'(kx_s1) * PROD_W'(step_x_q);
			prod_y_s2 <= PROD_W'(ky_s1) * PROD_W'(step_y_q);
			// Stage 3: centred position, biased by one for nearest and by a half for bilinear.
			op_s3    <= op_s2;
			pixel_s3 <= pixel_s2;
			cx_s3    <= cx_s2;
			cy_s3    <= cy_s2;
			pos_x_s3 <= POS_W'(prod_x_s2) + POS_W'(step_x_q >> 1) +
				(bilinear ? HALF_BIAS : ONE_BIAS);
			pos_y_s3 <= POS_W'(prod_y_s2) + POS_W'(step_y_q >> 1) +
				(bilinear ? HALF_BIAS : ONE_BIAS);
			// Stage 4: indexes and weights; loads and copies address directly.
			op_s4    <= op_s3;
			pixel_s4 <= pixel_s3;
			alpha_s4 <= bilinear;
			if (op_s3 == OP_LOAD || copy_mode) begin
				x0_s4 <= cx_s3;
				x1_s4 <= cx_s3;
				y0_s4 <= cy_s3;
				y1_s4 <= cy_s3;
				tx_s4 <= '0;
				ty_s4 <= '0;
			end else begin
				x0_s4 <= x0c[XW-1:0];
				x1_s4 <= x1c[XW-1:0];
				y0_s4 <= y0c[YW-1:0];
				y1_s4 <= y1c[YW-1:0];
				tx_s4 <= bilinear ? pos_x_s3[15:8] : 8'd0;
				ty_s4 <= bilinear ? pos_y_s3[15:8] : 8'd0;
			end
			// Stage 5: bank addresses.
			op_s5    <= op_s4;
			pixel_s5 <= pixel_s4;
			alpha_s5 <= alpha_s4;
			tx_s5    <= tx_s4;
			ty_s5    <= ty_s4;
			x0p_s5   <= x0_s4[0];
			x1p_s5   <= x1_s4[0];
			y0p_s5   <= y0_s4[0];
			y1p_s5   <= y1_s4[0];
			wbank_s5 <= {y0_s4[0], x0_s4[0]};
			// Stage 6: store access.
			alpha_s6 <= alpha_s5;
			tx_s6    <= tx_s5;
			ty_s6    <= ty_s5;
			x0p_s6   <= x0p_s5;
			x1p_s6   <= x1p_s5;
			y0p_s6   <= y0p_s5;
			y1p_s6   <= y1p_s5;
			// Stage 7: blend the two rows in each column.
			alpha_s7 <= alpha_s6;
			tx_s7    <= tx_s6;
			left_s7  <= blend(rd_s6[{y0p_s6, x0p_s6}], rd_s6[{y1p_s6, x0p_s6}], ty_s6);
			right_s7 <= blend(rd_s6[{y0p_s6, x1p_s6}], rd_s6[{y1p_s6, x1p_s6}], ty_s6);
			// Stage 8: blend the columns and force alpha in bilinear mode.
			out_pixel_q <= blend(left_s7, right_s7, tx_s7) |
				(alpha_s7 ? ALPHA_MASK : 32'h0);
		end
	end

	// Frame store in four banks by column and row parity, one read per bank.
	for (genvar b = 0; b < 4; b++) begin : g_bank
		logic [XW-1:0] bcx;
		logic [YW-1:0] bcy;
		logic [31:0]   mem [BANK_DEPTH];

		assign bcx = (x0_s4[0] == b[0]) ? x0_s4 : x1_s4;
		assign bcy = (y0_s4[0] == b[1]) ? y0_s4 : y1_s4;

		always_ff @(posedge clk) begin
			if (en) begin
				addr_s5[b] <= BAW'(32'(bcy >> 1) * 32'(HALF_W) + 32'(bcx >> 1));
				if (v_s5 && op_s5 == OP_LOAD && wbank_s5 == 2'(b)) begin
					mem[addr_s5[b]] <= pixel_s5;
				end
				rd_s6[b] <= mem[addr_s5[b]];
			end
		end
	end

	assign result.valid = out_valid_q;
	assign result.out_pixel = out_pixel_q;

	// Checks on the divider hold-off and on pipeline movement.
	logic [6:0] vbits;
	assign vbits = {v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7};

	`BIS_ASSERT_SAME(a_divider_blocks_input, clk, arst_n, busy_q || div_init_q, !item.ready)
	`BIS_ASSERT_NEXT(a_size_write_starts_divide, clk, arst_n, size_write, div_init_q)
	`BIS_ASSERT_NEXT(a_load_gives_no_result, clk, arst_n, en && v_s5 && !op_s5, !v_s6)
	`BIS_ASSERT_NEXT(a_stall_freezes_pipe, clk, arst_n, !en, $stable(vbits))

endmodule

`default_nettype wire

>>> bench/bilinear_image_scaler_tb.sv
// Self-checking testbench of the image scaler: frame store loads, sampling and all filter modes.
`timescale 1ns / 100ps

module bilinear_image_scaler_tb;
	import bis_pkg::*;

	localparam int STORE_W = 256;
	localparam int STORE_H = 256;
	localparam int SETTLE  = 16;

	typedef struct {
		logic [8:0]  src_w;
		logic [8:0]  src_h;
		logic [11:0] dst_w;
		logic [11:0] dst_h;
		logic [11:0] off_x;
		logic [11:0] off_y;
		logic        mode;
	} scale_cfg_t;

	typedef struct {
		logic        op;
		logic [11:0] col;
		logic [11:0] row;
		logic [31:0] pixel;
	} pix_req_t;

	// Source coordinates that one sample reads and the weights between them.
	typedef struct {
		bit          drawn;
		bit          mixed;
		int          x0;
		int          x1;
		int          y0;
		int          y1;
		logic [7:0]  tx;
		logic [7:0]  ty;
	} taps_t;

	logic clk;
	logic arst_n;

	bis_cfg_if cfg_ch ();
	bis_in_if  item_ch ();
	bis_out_if res_ch ();

	bilinear_image_scaler u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.item   (item_ch),
		.result (res_ch)
	);

	// Predictor state: the frame store copy and the live register values.
	logic [31:0] frame_copy [STORE_W*STORE_H];
	scale_cfg_t  live_cfg;
	// Settings the generator works with, and which store entries it has filled.
	scale_cfg_t  plan_cfg;
	bit          filled [STORE_W*STORE_H];

	pix_req_t    pending_reqs [$];
	logic [31:0] expected_pixels [$];
	int          cfg_writes;
	int          mismatches;
	int          pixels_checked;
	int          samples_sent;
	int          loads_sent;
	int          phases_run;

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic int clamp_index(int v, int top);
		if (v < 0)
			return 0;
		return (v > top) ? top : v;
	endfunction

	// Works out which source pixels a sample reads under a given setting.
	function automatic taps_t find_taps(scale_cfg_t c, logic [11:0] col, logic [11:0] row);
		taps_t t;
		int sw;
		int sh;
		int dx;
		int dy;
		longint stp_x;
		longint stp_y;
		longint pu;
		longint pv;
		t = '{default: 0};
		dx = int'(c.off_x) + int'(col);
		dy = int'(c.off_y) + int'(row);
		if (dx >= int'(c.dst_w) || dy >= int'(c.dst_h))
			return t;
		t.drawn = 1;
		sw = (c.src_w == 0) ? 1 : ((c.src_w > STORE_W) ? STORE_W : int'(c.src_w));
		sh = (c.src_h == 0) ? 1 : ((c.src_h > STORE_H) ? STORE_H : int'(c.src_h));
		if (int'(c.dst_w) == sw && int'(c.dst_h) == sh) begin
			t.x0 = dx;
			t.y0 = dy;
			return t;
		end
		stp_x = (longint'(sw) << 16) / longint'(c.dst_w);
		stp_y = (longint'(sh) << 16) / longint'(c.dst_h);
		pu = stp_x / 2 - 32768 + longint'(dx) * stp_x + 65536;
		pv = stp_y / 2 - 32768 + longint'(dy) * stp_y + 65536;
		if (c.mode == MODE_BILINEAR) begin
			t.mixed = 1;
			t.x0 = clamp_index(int'(pu >>> 16) - 1, sw - 1);
			t.x1 = clamp_index(int'(pu >>> 16), sw - 1);
			t.y0 = clamp_index(int'(pv >>> 16) - 1, sh - 1);
			t.y1 = clamp_index(int'(pv >>> 16), sh - 1);
			t.tx = 8'((pu & 64'hFFFF) >> 8);
			t.ty = 8'((pv & 64'hFFFF) >> 8);
		end else begin
			t.x0 = clamp_index(int'((pu + 32768) >>> 16) - 1, sw - 1);
			t.y0 = clamp_index(int'((pv + 32768) >>> 16) - 1, sh - 1);
		end
		return t;
	endfunction

	// Weighted mix of two pixels, red/blue and alpha/green lanes handled in pairs.
	function automatic logic [31:0] mix_pixels(logic [31:0] a, logic [31:0] b, logic [7:0] w);
		logic [31:0] wa;
		logic [31:0] wb;
		logic [31:0] rb;
		logic [31:0] ag;
		wa = 32'd256 - 32'(w);
		wb = 32'(w);
		rb = (((a & 32'h00FF00FF) * wa + (b & 32'h00FF00FF) * wb) >> 8) & 32'h00FF00FF;
		ag = (((a >> 8) & 32'h00FF00FF) * wa + ((b >> 8) & 32'h00FF00FF) * wb) & 32'hFF00FF00;
		return rb | ag;
	endfunction

	function automatic logic [31:0] scaled_pixel(taps_t t);
		logic [31:0] left;
		logic [31:0] right;
		if (!t.mixed)
			return frame_copy[t.y0*STORE_W + t.x0];
		left = mix_pixels(frame_copy[t.y0*STORE_W + t.x0], frame_copy[t.y1*STORE_W + t.x0], t.ty);
		right = mix_pixels(frame_copy[t.y0*STORE_W + t.x1], frame_copy[t.y1*STORE_W + t.x1], t.ty);
		return mix_pixels(left, right, t.tx) | ALPHA_MASK;
	endfunction

	// Request driver: bursts of random length separated by random gaps.
	int burst_left;
	int gap_left;
	always @(posedge clk or negedge arst_n) begin : drive_requests
		pix_req_t r;
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
			burst_left = 1;
			gap_left = 0;
		end else if (!item_ch.valid || item_ch.ready) begin
			if (gap_left > 0) begin
				gap_left--;
				item_ch.valid <= 1'b0;
			end else if (pending_reqs.size() > 0) begin
				r = pending_reqs.pop_front();
				item_ch.valid <= 1'b1;
				item_ch.operation <= r.op;
				item_ch.col <= r.col;
				item_ch.row <= r.row;
				item_ch.pixel <= r.pixel;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left--;
				end
			end else begin
				item_ch.valid <= 1'b0;
			end
		end
	end

	// Result receiver: ready follows a random 16-bit stall pattern that is redrawn periodically.
	logic [15:0] stall_pat;
	int          rx_cycle;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			stall_pat <= '1;
			rx_cycle <= 0;
		end else begin
			rx_cycle <= rx_cycle + 1;
			if (rx_cycle % 64 == 0)
				stall_pat <= ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
			res_ch.ready <= stall_pat[rx_cycle % 16];
		end
	end

	// Accepted requests update the store copy or queue the expected pixel.
	always @(posedge clk) begin : predict_requests
		taps_t t;
		if (arst_n && item_ch.valid && item_ch.ready) begin
			if (item_ch.operation == OP_LOAD) begin
				if (item_ch.col < STORE_W && item_ch.row < STORE_H)
					frame_copy[int'(item_ch.row)*STORE_W + int'(item_ch.col)] = item_ch.pixel;
			end else begin
				t = find_taps(live_cfg, item_ch.col, item_ch.row);
				if (t.drawn)
					expected_pixels.push_back(scaled_pixel(t));
			end
		end
	end

	// Register writes as they are accepted.
	always @(posedge clk) begin
		if (arst_n && cfg_ch.valid && cfg_ch.ready) begin
			case (cfg_ch.index)
				CFG_SRC_WIDTH:  live_cfg.src_w = cfg_ch.data[8:0];
				CFG_SRC_HEIGHT: live_cfg.src_h = cfg_ch.data[8:0];
				CFG_DST_WIDTH:  live_cfg.dst_w = cfg_ch.data;
				CFG_DST_HEIGHT: live_cfg.dst_h = cfg_ch.data;
				CFG_OFFSET_X:   live_cfg.off_x = cfg_ch.data;
				CFG_OFFSET_Y:   live_cfg.off_y = cfg_ch.data;
				CFG_FILTER:     live_cfg.mode = cfg_ch.data[0];
				default: ;
			endcase
			cfg_writes++;
		end
	end

	// Result check against the oldest expected pixel.
	always @(posedge clk) begin : check_results
		logic [31:0] want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (expected_pixels.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result pixel %08h with nothing pending", res_ch.out_pixel);
			end else begin
				want = expected_pixels.pop_front();
				pixels_checked++;
				if (res_ch.out_pixel !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Pixel mismatch: expected %08h, got %08h", want, res_ch.out_pixel);
				end
			end
		end
	end

	task automatic write_reg(logic [CFG_IW-1:0] idx, int value);
		int target;
		target = cfg_writes + 1;
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= CFG_DW'(value);
		wait (cfg_writes == target);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic push_load(int col, int row, logic [31:0] pix);
		if (col < STORE_W && row < STORE_H)
			filled[row*STORE_W + col] = 1;
		pending_reqs.push_back('{OP_LOAD, 12'(col), 12'(row), pix});
		loads_sent++;
	endtask

	// Loads every unfilled entry that a sample will read, then queues the sample.
	task automatic push_sample(int col, int row);
		taps_t t;
		int xs[2];
		int ys[2];
		t = find_taps(plan_cfg, 12'(col), 12'(row));
		if (t.drawn) begin
			xs[0] = t.x0;
			xs[1] = t.mixed ? t.x1 : t.x0;
			ys[0] = t.y0;
			ys[1] = t.mixed ? t.y1 : t.y0;
			foreach (xs[i])
				foreach (ys[j])
					if (!filled[ys[j]*STORE_W + xs[i]])
						push_load(xs[i], ys[j], $urandom);
		end
		pending_reqs.push_back('{OP_SAMPLE, 12'(col), 12'(row), 32'($urandom)});
		samples_sent++;
	endtask

	// Waits for every request to go in and every result to come out.
	task automatic drain();
		do @(posedge clk);
		while (pending_reqs.size() != 0 || item_ch.valid || expected_pixels.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_scaling(int sw, int sh, int dw, int dh, int ox, int oy, int md);
		drain();
		plan_cfg = '{9'(sw), 9'(sh), 12'(dw), 12'(dh), 12'(ox), 12'(oy), 1'(md)};
		write_reg(CFG_SRC_WIDTH, sw);
		write_reg(CFG_SRC_HEIGHT, sh);
		write_reg(CFG_DST_WIDTH, dw);
		write_reg(CFG_DST_HEIGHT, dh);
		write_reg(CFG_OFFSET_X, ox);
		write_reg(CFG_OFFSET_Y, oy);
		write_reg(CFG_FILTER, md);
		phases_run++;
	endtask

	// Mostly visible samples and some loads with random content; a few stray requests.
	task automatic random_traffic(int n);
		int vis_w;
		int vis_h;
		int pick;
		vis_w = int'(plan_cfg.dst_w) - int'(plan_cfg.off_x);
		vis_h = int'(plan_cfg.dst_h) - int'(plan_cfg.off_y);
		repeat (n) begin
			pick = $urandom_range(0, 9);
			if (pick < 6 && vis_w > 0 && vis_h > 0)
				push_sample($urandom_range(0, vis_w - 1), $urandom_range(0, vis_h - 1));
			else if (pick < 8)
				push_load($urandom_range(0, 15), $urandom_range(0, 15), $urandom);
			else if (pick < 9)
				push_sample($urandom_range(0, 4095), $urandom_range(0, 4095));
			else
				push_load($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		item_ch.valid = 1'b0;
		item_ch.operation = OP_LOAD;
		item_ch.col = '0;
		item_ch.row = '0;
		item_ch.pixel = '0;
		res_ch.ready = 1'b0;
		live_cfg = '{9'd256, 9'd256, 12'd256, 12'd256, 12'd0, 12'd0, 1'b0};
		plan_cfg = live_cfg;
		cfg_writes = 0;
		mismatches = 0;
		pixels_checked = 0;
		samples_sent = 0;
		loads_sent = 0;
		phases_run = 0;
		foreach (filled[i])
			filled[i] = 0;
		foreach (frame_copy[i])
			frame_copy[i] = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Equal-size copy with extreme pixels, stray loads and samples off the rectangle.
		set_scaling(4, 3, 4, 3, 0, 0, 0);
		push_load(0, 0, 32'h0000_0000);
		push_load(3, 2, 32'hFFFF_FFFF);
		push_load(4095, 4095, 32'hA5A5_A5A5);
		push_load(255, 255, 32'h1234_5678);
		push_load(256, 0, 32'h5A5A_5A5A);
		push_sample(0, 0);
		push_sample(3, 2);
		push_sample(255, 255);
		push_sample(4, 0);
		push_sample(0, 4095);
		// Bilinear upscale, nearest downscale, a single source pixel stretched far.
		set_scaling(5, 4, 13, 9, 0, 0, 1);
		push_sample(0, 0);
		push_sample(12, 8);
		push_sample(6, 4);
		set_scaling(7, 6, 3, 2, 0, 0, 0);
		push_sample(0, 0);
		push_sample(2, 1);
		set_scaling(1, 1, 4095, 4095, 4090, 4093, 1);
		push_sample(0, 0);
		push_sample(4, 1);
		push_sample(5, 2);
		// Source sizes of zero and above the store are clamped.
		set_scaling(0, 300, 5, 6, 0, 0, 0);
		push_sample(4, 5);
		push_sample(0, 3);
		set_scaling(256, 256, 256, 256, 0, 0, 0);
		push_sample(255, 255);
		push_sample(128, 7);

		// Fixed extreme settings, then random ones.
		set_scaling(256, 256, 7, 5, 2, 1, 1);
		random_traffic(30);
		set_scaling(9, 8, 1, 1, 0, 0, 1);
		random_traffic(20);
		set_scaling(511, 1, 4095, 3, 0, 0, 0);
		random_traffic(30);
		set_scaling(16, 16, 40, 33, 3, 4, 1);
		random_traffic(40);
		repeat (10) begin
			set_scaling($urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(1, 40),
				$urandom_range(1, 40), $urandom_range(0, 6), $urandom_range(0, 6),
				$urandom_range(0, 1));
			random_traffic(35);
		end

		drain();
		$display("Ran %0d register settings with %0d loads and %0d samples.",
			phases_run, loads_sent, samples_sent);
		$display("Checked %0d output pixels, %0d mismatches.", pixels_checked, mismatches);
		if (mismatches == 0 && expected_pixels.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("Run timed out.");
		$display("FAILED: results differ");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/bis_pkg.sv
rtl/core/bis_if.sv
rtl/core/bilinear_image_scaler.sv
bench/bilinear_image_scaler_tb.sv
